// ===== hw/rtl/vna_pkg.sv =====
// ---------------------------------------------------------------------------
// vna_pkg
// Shared types and codes for the vertex normal accumulator.
// ---------------------------------------------------------------------------
package vna_pkg;

    localparam int IDX_W = 10;
    localparam int POS_W = 24;
    localparam int VC_W  = 11;
    localparam int NRM_W = 16;

    localparam logic [VC_W-1:0] VC_RESET = 11'd1024;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_TRIANGLE = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
    } out_item_t;

    typedef struct packed {
        logic     err;
        in_item_t item;
    } cmd_t;

endpackage

// ===== hw/rtl/vna_queue.sv =====
// ---------------------------------------------------------------------------
// vna_queue
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module vna_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                data_reg [DEPTH];
    logic [PW-1:0]   wr_reg;
    logic [PW-1:0]   rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = data_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/vna_front.sv =====
// ---------------------------------------------------------------------------
// vna_front
// Holds the vertex count and classifies incoming items for range errors.
// ---------------------------------------------------------------------------
module vna_front #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vna_pkg::in_item_t           item,
    output vna_pkg::cmd_t               cmd,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [vna_pkg::VC_W-1:0]    cfg_data
);
    import vna_pkg::*;

    localparam int CW = ($clog2(MAX_VERTICES + 1) > VC_W) ? $clog2(MAX_VERTICES + 1) : VC_W;

    logic [VC_W-1:0] vertex_count_reg;
    logic [CW-1:0]   cnt_eff;
    logic            ok_idx;
    logic            ok_a;
    logic            ok_b;
    logic            ok_c;
    logic            err;

    assign cfg_ready = 1'b1;
    assign cnt_eff   = (CW'(vertex_count_reg) < CW'(MAX_VERTICES)) ?
                       CW'(vertex_count_reg) : CW'(MAX_VERTICES);
    assign ok_idx    = CW'(item.vertex_index) < cnt_eff;
    assign ok_a      = CW'(item.corner_a) < cnt_eff;
    assign ok_b      = CW'(item.corner_b) < cnt_eff;
    assign ok_c      = CW'(item.corner_c) < cnt_eff;

    always_comb
    begin
        case (item.opcode)
            OP_LOAD:     err = ~ok_idx;
            OP_READ:     err = ~ok_idx;
            OP_TRIANGLE: err = ~(ok_a & ok_b & ok_c);
            default:     err = 1'b1;
        endcase
    end

    assign cmd.err  = err;
    assign cmd.item = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VC_RESET;
        end
        else if (cfg_valid)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

endmodule

// ===== hw/rtl/vna_back.sv =====
// ---------------------------------------------------------------------------
// vna_back
// Sequencer over the position and sum memories: load, triangle
// accumulate, and block-scaled normalize with iterative root and divide.
// ---------------------------------------------------------------------------
module vna_back #(
    parameter int MAX_VERTICES  = 1024,
    parameter int POSITION_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vna_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  logic               res_full,
    output logic               res_push,
    output vna_pkg::out_item_t res,
    output logic               clearing
);
    import vna_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int PB = POSITION_BITS;
    localparam int DW = PB + 1;
    localparam int MW = (DW > 32) ? DW : 32;
    localparam int PW = 2 * MW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RB, S_RC, S_D1, S_D2, S_MUL, S_ARD, S_AWR,
        S_RWAIT, S_NORM, S_SQ, S_ROOT, S_DINIT, S_DIV, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          clr_reg;
    in_item_t               cur_reg;
    out_item_t              res_reg;

    logic [3*PB-1:0]        pos_mem [MAX_VERTICES];
    logic [3*PB-1:0]        pos_q;
    logic                   pos_we;
    logic                   pos_re;
    logic [AW-1:0]          pos_waddr;
    logic [AW-1:0]          pos_raddr;
    logic [3*PB-1:0]        pos_wdata;

    logic [191:0]           sum_mem [MAX_VERTICES];
    logic [191:0]           sum_q;
    logic                   sum_we;
    logic                   sum_re;
    logic [AW-1:0]          sum_waddr;
    logic [AW-1:0]          sum_raddr;
    logic [191:0]           sum_wdata;

    logic signed [PB-1:0]   pq [3];
    logic signed [PB-1:0]   pa_reg [3];
    logic signed [PB-1:0]   pb_reg [3];
    logic signed [DW-1:0]   u_reg [3];
    logic signed [DW-1:0]   v_reg [3];
    logic [2:0]             k_reg;
    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [2*MW-1:0] mul_p;
    logic signed [2*MW-1:0] prod_reg;
    logic signed [2*MW-1:0] first_reg;
    logic signed [63:0]     n_reg [3];
    logic [1:0]             corner_reg;
    logic [AW-1:0]          corner_addr;

    logic signed [63:0]     sq_sum [3];
    logic [63:0]            mag [3];
    logic signed [63:0]     s_reg [3];
    logic [63:0]            m_reg [3];
    logic [63:0]            m_or;
    logic [61:0]            sq_reg;
    logic [61:0]            sq_next;
    logic [61:0]            rv_reg;
    logic [61:0]            root_reg;
    logic [61:0]            bit_reg;
    logic [61:0]            trial;
    logic [31:0]            len_c;
    logic [1:0]             comp_reg;
    logic [3:0]             dstep_reg;
    logic [31:0]            rem_reg;
    logic [14:0]            nlow_reg;
    logic [14:0]            q_reg;
    logic [44:0]            num_c;
    logic [32:0]            t_c;
    logic                   ge_c;
    logic [14:0]            qf_c;
    logic signed [15:0]     qs_c;
    logic                   start;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
        return AW'(i);
    endfunction

    function automatic logic signed [63:0] sat_cross(input logic signed [PW-1:0] d);
        logic [PW-64:0] hi;
        hi = d[PW-1:63];
        if ((&hi) || (~|hi))
        begin
            return d[63:0];
        end
        return d[PW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    assign start    = (state_reg == S_IDLE) && cmd_valid && !res_full;
    assign cmd_pop  = start;
    assign res_push = (state_reg == S_DONE);
    assign res      = res_reg;
    assign clearing = (state_reg == S_CLEAR);

    assign pq[0] = pos_q[3*PB-1:2*PB];
    assign pq[1] = pos_q[2*PB-1:PB];
    assign pq[2] = pos_q[PB-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_sum[i] = sum_q[191-64*i -: 64];
            mag[i]    = sq_sum[i][63] ? 64'(-sq_sum[i]) : 64'(sq_sum[i]);
        end
    end

    always_comb
    begin
        case (corner_reg)
            2'd0:    corner_addr = to_addr(cur_reg.corner_a);
            2'd1:    corner_addr = to_addr(cur_reg.corner_b);
            default: corner_addr = to_addr(cur_reg.corner_c);
        endcase
    end

    always_comb
    begin
        pos_we    = start && !cmd.err && (cmd.item.opcode == OP_LOAD);
        pos_waddr = to_addr(cmd.item.vertex_index);
        pos_wdata = {PB'(cmd.item.pos_x), PB'(cmd.item.pos_y), PB'(cmd.item.pos_z)};
        pos_re    = 1'b0;
        pos_raddr = to_addr(cur_reg.corner_b);
        sum_we    = 1'b0;
        sum_waddr = clr_reg;
        sum_wdata = '0;
        sum_re    = 1'b0;
        sum_raddr = corner_addr;
        case (state_reg)
            S_CLEAR:
            begin
                sum_we = 1'b1;
            end
            S_IDLE:
            begin
                if (start && !cmd.err)
                begin
                    case (cmd.item.opcode)
                        OP_LOAD:
                        begin
                            sum_we    = 1'b1;
                            sum_waddr = to_addr(cmd.item.vertex_index);
                        end
                        OP_TRIANGLE:
                        begin
                            pos_re    = 1'b1;
                            pos_raddr = to_addr(cmd.item.corner_a);
                        end
                        OP_READ:
                        begin
                            sum_re    = 1'b1;
                            sum_raddr = to_addr(cmd.item.vertex_index);
                        end
                        default:
                        begin
                            sum_re = 1'b0;
                        end
                    endcase
                end
            end
            S_RB:
            begin
                pos_re = 1'b1;
            end
            S_RC:
            begin
                pos_re    = 1'b1;
                pos_raddr = to_addr(cur_reg.corner_c);
            end
            S_ARD:
            begin
                sum_re = 1'b1;
            end
            S_AWR:
            begin
                sum_we    = 1'b1;
                sum_waddr = corner_addr;
                sum_wdata = {sat_add(sq_sum[0], n_reg[0]), sat_add(sq_sum[1], n_reg[1]),
                             sat_add(sq_sum[2], n_reg[2])};
            end
            default:
            begin
                sum_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_re)
        begin
            pos_q <= pos_mem[pos_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re)
        begin
            sum_q <= sum_mem[sum_raddr];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SQ)
        begin
            case (k_reg)
                3'd0:
                begin
                    mul_a = $signed(MW'({1'b0, m_reg[0][29:0]}));
                    mul_b = mul_a;
                end
                3'd1:
                begin
                    mul_a = $signed(MW'({1'b0, m_reg[1][29:0]}));
                    mul_b = mul_a;
                end
                3'd2:
                begin
                    mul_a = $signed(MW'({1'b0, m_reg[2][29:0]}));
                    mul_b = mul_a;
                end
                default:
                begin
                    mul_a = '0;
                end
            endcase
        end
        else
        begin
            case (k_reg)
                3'd0:
                begin
                    mul_a = MW'(u_reg[1]);
                    mul_b = MW'(v_reg[2]);
                end
                3'd1:
                begin
                    mul_a = MW'(u_reg[2]);
                    mul_b = MW'(v_reg[1]);
                end
                3'd2:
                begin
                    mul_a = MW'(u_reg[2]);
                    mul_b = MW'(v_reg[0]);
                end
                3'd3:
                begin
                    mul_a = MW'(u_reg[0]);
                    mul_b = MW'(v_reg[2]);
                end
                3'd4:
                begin
                    mul_a = MW'(u_reg[0]);
                    mul_b = MW'(v_reg[1]);
                end
                3'd5:
                begin
                    mul_a = MW'(u_reg[1]);
                    mul_b = MW'(v_reg[0]);
                end
                default:
                begin
                    mul_a = '0;
                end
            endcase
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign m_or    = m_reg[0] | m_reg[1] | m_reg[2];
    assign sq_next = sq_reg + prod_reg[61:0];
    assign trial   = root_reg + bit_reg;
    assign len_c   = root_reg[31:0];
    assign num_c   = {1'b0, m_reg[comp_reg][29:0], 14'd0} + {14'd0, len_c[31:1]};
    assign t_c     = {rem_reg, nlow_reg[14]};
    assign ge_c    = t_c >= {1'b0, len_c};
    assign qf_c    = {q_reg[13:0], ge_c};
    assign qs_c    = s_reg[comp_reg][63] ? -$signed({1'b0, qf_c}) : $signed({1'b0, qf_c});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(MAX_VERTICES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cur_reg <= cmd.item;
                        res_reg <= '{status: (cmd.err ? ST_RANGE : ST_OK),
                                     normal_x: '0, normal_y: '0, normal_z: '0};
                        if (cmd.err)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            case (cmd.item.opcode)
                                OP_TRIANGLE: state_reg <= S_RB;
                                OP_READ:     state_reg <= S_RWAIT;
                                default:     state_reg <= S_DONE;
                            endcase
                        end
                    end
                end
                S_RB:
                begin
                    pa_reg    <= pq;
                    state_reg <= S_RC;
                end
                S_RC:
                begin
                    pb_reg    <= pq;
                    state_reg <= S_D1;
                end
                S_D1:
                begin
                    state_reg <= S_D2;
                end
                S_D2:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        u_reg[i] <= DW'(pq[i]) - DW'(pa_reg[i]);
                        v_reg[i] <= DW'(pb_reg[i]) - DW'(pa_reg[i]);
                    end
                    k_reg     <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg <= mul_p;
                    k_reg    <= k_reg + 1'b1;
                    if (k_reg != 3'd0)
                    begin
                        if (k_reg[0])
                        begin
                            first_reg <= prod_reg;
                        end
                        else
                        begin
                            n_reg[(k_reg[2:1]) - 2'd1] <= sat_cross(PW'(first_reg) - PW'(prod_reg));
                        end
                    end
                    if (k_reg == 3'd6)
                    begin
                        corner_reg <= 2'd0;
                        state_reg  <= S_ARD;
                    end
                end
                S_ARD:
                begin
                    state_reg <= S_AWR;
                end
                S_AWR:
                begin
                    corner_reg <= corner_reg + 1'b1;
                    state_reg  <= (corner_reg == 2'd2) ? S_DONE : S_ARD;
                end
                S_RWAIT:
                begin
                    s_reg <= sq_sum;
                    m_reg <= mag;
                    if ((mag[0] | mag[1] | mag[2]) == '0)
                    begin
                        res_reg.status <= ST_ZERO;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (|m_or[63:30])
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                    end
                    else if (!m_or[29])
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        k_reg     <= '0;
                        sq_reg    <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    prod_reg <= mul_p;
                    k_reg    <= k_reg + 1'b1;
                    if (k_reg != 3'd0)
                    begin
                        sq_reg <= sq_next;
                    end
                    if (k_reg == 3'd3)
                    begin
                        rv_reg    <= sq_next;
                        root_reg  <= '0;
                        bit_reg   <= 62'd1 << 60;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (rv_reg >= trial)
                    begin
                        rv_reg   <= rv_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= S_DINIT;
                    end
                end
                S_DINIT:
                begin
                    rem_reg   <= 32'(num_c[44:15]);
                    nlow_reg  <= num_c[14:0];
                    q_reg     <= '0;
                    dstep_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg   <= ge_c ? 32'(t_c - {1'b0, len_c}) : t_c[31:0];
                    nlow_reg  <= nlow_reg << 1;
                    q_reg     <= qf_c;
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == 4'd14)
                    begin
                        case (comp_reg)
                            2'd0:    res_reg.normal_x <= qs_c;
                            2'd1:    res_reg.normal_y <= qs_c;
                            default: res_reg.normal_z <= qs_c;
                        endcase
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= (comp_reg == 2'd2) ? S_DONE : S_DINIT;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result transfer into a full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty queue");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DINIT) |-> (root_reg[61:32] == '0 && root_reg[31:29] != '0))
        else $error("root outside the scaled range");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < len_c))
        else $error("divide remainder not below divisor");

endmodule

// ===== hw/rtl/vertex_normal_accumulator.sv =====
// ---------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted smooth vertex normals: load, triangle add, normalized read.
// ---------------------------------------------------------------------------
// Each transfer in yields one result; loads, rejected items, triangles and
// reads (normalize shift, 31-step root, three 15-step divides) are all worked
// by the one back-end sequencer.
// One item is worked at a time; a two-entry queue on each side decouples.
// After reset the sum memory is swept to zero with full held high;
// vertex_count resets to 1024.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES  = 1024,
    parameter int POSITION_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  vna_pkg::in_item_t        item,
    output logic                     empty,
    input  logic                     pop,
    output vna_pkg::out_item_t       result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [vna_pkg::VC_W-1:0] cfg_data
);
    import vna_pkg::*;

    cmd_t      front_cmd;
    cmd_t      back_cmd;
    logic      cmdq_full;
    logic      cmdq_empty;
    logic      cmd_pop;
    logic      res_push;
    logic      resq_full;
    out_item_t back_res;
    logic      clearing;

    assign full = cmdq_full | clearing;

    vna_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (front_cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    vna_queue #(
        .T     (cmd_t),
        .DEPTH (2)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push & ~full),
        .wdata (front_cmd),
        .full  (cmdq_full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmdq_empty)
    );

    vna_back #(
        .MAX_VERTICES  (MAX_VERTICES),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (~cmdq_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (resq_full),
        .res_push  (res_push),
        .res       (back_res),
        .clearing  (clearing)
    );

    vna_queue #(
        .T     (out_item_t),
        .DEPTH (2)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (resq_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule
